@@ rtl/core/wavetable_oscillator_unit_defines.svh @@
// assertion macros shared by the oscillator rtl
`ifndef WAVETABLE_OSCILLATOR_UNIT_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WOSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WOSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/wosc_pkg.sv @@
// types, constants and the cosine quarter-wave rom of the wavetable oscillator
package wosc_pkg;

    localparam int TABLE_POINTS        = 1024;
    localparam int PHASE_FRACTION_BITS = 16;
    localparam int IDX_W               = $clog2(TABLE_POINTS);
    localparam int PHASE_W             = IDX_W + PHASE_FRACTION_BITS;
    localparam int HALF                = TABLE_POINTS / 2;
    localparam int QUARTER             = TABLE_POINTS / 4;
    localparam int COS_ADDR_W          = $clog2(QUARTER + 1);
    localparam int TRI_SHIFT           = 17 - IDX_W;
    localparam int SAW_SHIFT           = 16 - IDX_W;

    localparam int MAX_CHANNELS = 8;
    localparam int CHAN_W       = $clog2(MAX_CHANNELS);
    localparam int CHCNT_W      = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PHASE_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // waveform codes
    localparam logic [1:0] WAVE_COSINE   = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd2;
    localparam logic [1:0] WAVE_SQUARE   = 2'd3;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] existing;
        logic               block_end;
    } t_slot;

    typedef struct packed {
        logic signed [PHASE_W-1:0] increment;
        logic [CHCNT_W-1:0]        channel_count;
    } t_front_cfg;

    typedef struct packed {
        logic [1:0]  waveform;
        logic [15:0] amplitude;
        logic        add_mode;
    } t_back_cfg;

    typedef logic [15:0] t_cos_rom [QUARTER+1];

    // cos(pi*2j/N) magnitude in q.15 from a q30 taylor series, evaluated at elaboration
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom           rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int j = 0; j <= QUARTER; j++) begin
            x    = (64'(2 * j) * PI_Q30) / 64'(TABLE_POINTS);
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = $signed(ONE_Q30);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k & 1) != 0) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            rom[j] = 16'((sum + 64'sd16384) >>> 15);
        end
        return rom;
    endfunction

    localparam t_cos_rom COS_ROM = build_cos_rom();

endpackage

@@ rtl/core/wosc_in_if.sv @@
// input channel: existing buffer slot value and block end flag
interface wosc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] existing_sample;
    logic               block_end;

    modport source (output valid, existing_sample, block_end, input ready);
    modport sink   (input valid, existing_sample, block_end, output ready);
endinterface

@@ rtl/core/wosc_out_if.sv @@
// output channel: new buffer slot value and block end flag
interface wosc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               block_end_out;

    modport source (output valid, sample_out, block_end_out, input ready);
    modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

@@ rtl/core/wavetable_oscillator_unit.sv @@
// wavetable oscillator top level: config registers, front end, queue, back end
//
// usage:
//   i_slot transfers one buffer slot (existing_sample, block_end); o_slot transfers
//   the new slot value (sample_out, block_end_out), one result per input transfer,
//   in order. both channels are valid/ready.
//   config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 waveform,
//   1 phase increment, 2 amplitude, 3 add mode, 4 channel count); other indexes
//   are ignored. write only while no slot is in flight.
//   path: an input transfer reaches o_slot through the queue entry, the rom read,
//   the multiply and the add/saturate into the output register, each registered.
//   throughput: one slot per cycle while o_slot is not stalled; the front adds the
//   phase and the back does one 17x17 multiply per slot, each stage registered.
//   reset (i_rst_n low, synchronous): phase and channel index cleared, registers
//   back to cosine, zero increment, amplitude 0.5, overwrite, one channel; queue
//   and pipe emptied.
//   stall: when o_slot.ready is low with a result held, the back pipe freezes; the
//   front keeps taking slots until the four-entry queue fills, then drops i_slot.ready.
module wavetable_oscillator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wosc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wosc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    wosc_in_if.sink                             i_slot,
    wosc_out_if.source                          o_slot
);
    import wosc_pkg::*;

    logic [1:0]                r_waveform;
    logic signed [PHASE_W-1:0] r_increment;
    logic [15:0]               r_amplitude;
    logic                      r_add_mode;
    logic [CHCNT_W-1:0]        r_channel_count;

    t_front_cfg front_cfg;
    t_back_cfg  back_cfg;

    // front to queue
    logic  push_valid;
    logic  push_ready;
    t_slot push_data;

    // queue to back
    logic  pop_valid;
    logic  pop_ready;
    t_slot pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform      <= WAVE_COSINE;
            r_increment     <= '0;
            r_amplitude     <= 16'd16384;
            r_add_mode      <= 1'b0;
            r_channel_count <= CHCNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVEFORM:      r_waveform      <= i_cfg_data[1:0];
                CFG_PHASE_INC:     r_increment     <= $signed(i_cfg_data[PHASE_W-1:0]);
                CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[15:0];
                CFG_ADD_MODE:      r_add_mode      <= i_cfg_data[0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHCNT_W-1:0];
                default:           ; // unmapped index, write dropped
            endcase
        end
    end

    assign front_cfg.increment     = r_increment;
    assign front_cfg.channel_count = r_channel_count;
    assign back_cfg.waveform       = r_waveform;
    assign back_cfg.amplitude      = r_amplitude;
    assign back_cfg.add_mode       = r_add_mode;

    // phase and channel bookkeeping at input transfer time
    wosc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (front_cfg),
        .i_slot       (i_slot),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // decouples input acceptance from output stalls
    wosc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // waveform, scaling and saturation pipe
    wosc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_slot      (o_slot)
    );

endmodule

@@ rtl/core/wosc_front.sv @@
// front end: takes slots, tracks channel and phase, emits rounded table index
`include "wavetable_oscillator_unit_defines.svh"

module wosc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wosc_pkg::t_front_cfg i_cfg,
    wosc_in_if.sink             i_slot,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output wosc_pkg::t_slot     o_push_data
);
    import wosc_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [CHAN_W-1:0]  r_chan;
    logic [PHASE_W:0]   round_sum;
    logic [CHCNT_W-1:0] chans;
    logic               frame_end;
    logic               accept;

    // round to nearest point, wrap past the end
    assign round_sum = {1'b0, r_phase} + (PHASE_W + 1)'(1 << (PHASE_FRACTION_BITS - 1));

    always_comb begin
        if (i_cfg.channel_count == '0) begin
            chans = CHCNT_W'(1);
        end else if (i_cfg.channel_count > CHCNT_W'(MAX_CHANNELS)) begin
            chans = CHCNT_W'(MAX_CHANNELS);
        end else begin
            chans = i_cfg.channel_count;
        end
    end

    assign frame_end = ((CHCNT_W'(r_chan) + CHCNT_W'(1)) >= chans) || i_slot.block_end;
    assign n_phase   = r_phase + $unsigned(i_cfg.increment);

    assign o_push_valid          = i_slot.valid;
    assign i_slot.ready          = i_push_ready;
    assign accept                = i_slot.valid && i_push_ready;
    assign o_push_data.idx       = round_sum[PHASE_W-1:PHASE_FRACTION_BITS];
    assign o_push_data.existing  = i_slot.existing_sample;
    assign o_push_data.block_end = i_slot.block_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_chan  <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_phase <= n_phase;
                r_chan  <= '0;
            end else begin
                r_chan  <= r_chan + CHAN_W'(1);
            end
        end
    end

    `WOSC_ASSERT_NEXT(a_frame_end_clears_chan, i_clk, i_rst_n, accept && frame_end, r_chan == '0, "channel index not cleared at frame end")
    `WOSC_ASSERT_NEXT(a_phase_holds_in_frame, i_clk, i_rst_n, accept && !frame_end, $stable(r_phase), "phase moved inside a frame")

endmodule

@@ rtl/core/wosc_queue.sv @@
// short fifo between front and back
`include "wavetable_oscillator_unit_defines.svh"

module wosc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  wosc_pkg::t_slot i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output wosc_pkg::t_slot o_pop_data
);
    import wosc_pkg::*;

    t_slot              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `WOSC_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "queue fill count beyond depth")

endmodule

@@ rtl/core/wosc_back.sv @@
// back end: waveform lookup, amplitude scaling, add and saturate, output register
`include "wavetable_oscillator_unit_defines.svh"

module wosc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wosc_pkg::t_back_cfg i_cfg,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  wosc_pkg::t_slot    i_pop_data,
    wosc_out_if.source         o_slot
);
    import wosc_pkg::*;

    logic                  advance;
    logic [IDX_W:0]        fold;
    logic [COS_ADDR_W-1:0] cos_addr;
    logic                  cos_neg;
    logic signed [17:0]    alt;

    logic                  r_s1_valid;
    logic [15:0]           r_s1_cos;
    logic                  r_s1_neg;
    logic signed [17:0]    r_s1_alt;
    logic signed [15:0]    r_s1_existing;
    logic                  r_s1_end;

    logic signed [16:0]    wave;
    logic                  r_s2_valid;
    logic signed [33:0]    r_s2_prod;
    logic signed [15:0]    r_s2_existing;
    logic                  r_s2_end;

    logic signed [33:0]    rounded;
    logic signed [19:0]    smp;
    logic signed [19:0]    pick;
    logic signed [15:0]    sat;
    logic                  r_out_valid;
    logic signed [15:0]    r_out_sample;
    logic                  r_out_end;

    // whole pipe moves unless the output register is full and stalled
    assign advance     = !r_out_valid || o_slot.ready;
    assign o_pop_ready = advance;

    // fold the point onto the first quadrant of the cosine
    always_comb begin
        if (i_pop_data.idx <= IDX_W'(HALF)) begin
            fold = {1'b0, i_pop_data.idx};
        end else begin
            fold = (IDX_W + 1)'(TABLE_POINTS) - {1'b0, i_pop_data.idx};
        end
        if (fold <= (IDX_W + 1)'(QUARTER)) begin
            cos_addr = COS_ADDR_W'(fold);
            cos_neg  = 1'b0;
        end else begin
            cos_addr = COS_ADDR_W'((IDX_W + 1)'(HALF) - fold);
            cos_neg  = 1'b1;
        end
    end

    always_comb begin
        case (i_cfg.waveform)
            WAVE_TRIANGLE: begin
                if (!i_pop_data.idx[IDX_W-1]) begin
                    alt = (18'(i_pop_data.idx[IDX_W-2:0]) << TRI_SHIFT) - 18'sd32768;
                end else begin
                    alt = 18'sd32768 - (18'(i_pop_data.idx[IDX_W-2:0]) << TRI_SHIFT);
                end
            end
            WAVE_SAWTOOTH: alt = (18'(i_pop_data.idx) << SAW_SHIFT) - 18'sd32768;
            WAVE_SQUARE:   alt = i_pop_data.idx[IDX_W-1] ? -18'sd32768 : 18'sd32768;
            default:       alt = '0;
        endcase
    end

    always_comb begin
        if (i_cfg.waveform == WAVE_COSINE) begin
            wave = r_s1_neg ? -$signed({1'b0, r_s1_cos}) : $signed({1'b0, r_s1_cos});
        end else begin
            wave = r_s1_alt[16:0];
        end
    end

    // round half up, then optional add of the existing slot, then clamp
    assign rounded = r_s2_prod + 34'sd16384;
    assign smp     = {rounded[33], rounded[33:15]};

    always_comb begin
        if (i_cfg.add_mode) begin
            pick = smp + {{4{r_s2_existing[15]}}, r_s2_existing};
        end else begin
            pick = smp;
        end
        if (pick > 20'sd32767) begin
            sat = 16'sh7FFF;
        end else if (pick < -20'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = pick[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cos      <= COS_ROM[cos_addr];
            r_s1_neg      <= cos_neg;
            r_s1_alt      <= alt;
            r_s1_existing <= i_pop_data.existing;
            r_s1_end      <= i_pop_data.block_end;
            r_s2_prod     <= $signed({1'b0, i_cfg.amplitude}) * wave;
            r_s2_existing <= r_s1_existing;
            r_s2_end      <= r_s1_end;
            r_out_sample  <= sat;
            r_out_end     <= r_s2_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_pop_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_slot.valid         = r_out_valid;
    assign o_slot.sample_out    = r_out_sample;
    assign o_slot.block_end_out = r_out_end;

    `WOSC_ASSERT_NEXT(a_stall_freezes_pipe, i_clk, i_rst_n, !advance, $stable(r_s1_valid) && $stable(r_s2_valid) && r_out_valid, "pipeline moved during output stall")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the wavetable oscillator unit, directed and random slot traffic
module testbench;
    import wosc_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT     = 400000;
    localparam int BATCHES         = 10;
    localparam int BATCH_SLOTS     = 128;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int REPORT_CAP      = 100;

    // q30 constants for the cosine series
    localparam logic [63:0] TAYLOR_PI  = 64'd3373259426;
    localparam logic [63:0] TAYLOR_ONE = 64'd1073741824;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               block_end;
    } t_slot_result;

    // predicts the slot values the oscillator writes and holds them until they come out
    class slot_scoreboard;
        logic [1:0]         wave;
        logic [PHASE_W-1:0] increment;
        logic [15:0]        gain;
        logic               add_mode;
        logic [CHCNT_W-1:0] chan_count;
        logic [PHASE_W-1:0] phase;
        logic [CHAN_W-1:0]  chan_idx;
        t_slot_result       expected_slots[$];
        int                 slots_in;
        int                 slots_out;
        int                 mismatches;

        // register values after reset, phase and channel cleared
        function new();
            wave       = WAVE_COSINE;
            increment  = '0;
            gain       = 16'd16384;
            add_mode   = 1'b0;
            chan_count = CHCNT_W'(1);
            phase      = '0;
            chan_idx   = '0;
            slots_in   = 0;
            slots_out  = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_WAVEFORM:      wave = data[1:0];
                CFG_PHASE_INC:     increment = data[PHASE_W-1:0];
                CFG_AMPLITUDE:     gain = data[15:0];
                CFG_ADD_MODE:      add_mode = data[0];
                CFG_CHANNEL_COUNT: chan_count = data[CHCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // waveform value at one table point, q.15 with +1.0 = 32768
        function longint waveform_level(int unsigned point);
            longint unsigned turn2;
            longint unsigned arc;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          sum;
            bit              negate;
            case (wave)
                WAVE_TRIANGLE: begin
                    if (point < HALF) begin
                        return longint'((point * 131072) / TABLE_POINTS) - 32768;
                    end
                    return 32768 - longint'(((point - HALF) * 131072) / TABLE_POINTS);
                end
                WAVE_SAWTOOTH: return longint'((point * 65536) / TABLE_POINTS) - 32768;
                WAVE_SQUARE:   return (point < HALF) ? 32768 : -32768;
                default: begin
                    // fold onto the first quadrant in half-point steps
                    turn2 = 2 * point;
                    if (turn2 > TABLE_POINTS) begin
                        turn2 = 2 * TABLE_POINTS - turn2;
                    end
                    negate = (2 * turn2 > TABLE_POINTS);
                    arc    = negate ? TABLE_POINTS - turn2 : turn2;
                    // nine-term taylor series of cos in q30
                    x    = (arc * TAYLOR_PI) / TABLE_POINTS;
                    x2   = (x * x) >> 30;
                    term = TAYLOR_ONE;
                    sum  = longint'(TAYLOR_ONE);
                    for (int k = 1; k <= 8; k++) begin
                        term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
                        if (k % 2 == 1) begin
                            sum = sum - longint'(term);
                        end else begin
                            sum = sum + longint'(term);
                        end
                    end
                    if (sum < 0) begin
                        sum = 0;
                    end
                    sum = (sum + 16384) >>> 15;
                    return negate ? -sum : sum;
                end
            endcase
        endfunction

        // one accepted input transfer: expected slot value, then phase/channel advance
        function void take_slot(logic signed [15:0] existing, logic last);
            int unsigned  point;
            int unsigned  chans;
            longint       scaled;
            longint       total;
            t_slot_result slot;
            point  = ((phase + (1 << (PHASE_FRACTION_BITS - 1))) >> PHASE_FRACTION_BITS)
                     % TABLE_POINTS;
            scaled = (longint'(gain) * waveform_level(point) + 16384) >>> 15;
            total  = add_mode ? longint'(existing) + scaled : scaled;
            if (total > 32767) begin
                total = 32767;
            end else if (total < -32768) begin
                total = -32768;
            end
            slot.sample    = total[15:0];
            slot.block_end = last;
            expected_slots.push_back(slot);
            slots_in++;
            chans = (chan_count == 0) ? 1 : (chan_count > MAX_CHANNELS) ? MAX_CHANNELS : chan_count;
            if (chan_idx + 1 >= chans || last) begin
                chan_idx = '0;
                phase    = phase + increment;
            end else begin
                chan_idx = chan_idx + 1'b1;
            end
        endfunction

        // one accepted output transfer against the oldest expected slot
        function void check_slot(logic signed [15:0] sample, logic last);
            t_slot_result want;
            slots_out++;
            if (expected_slots.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP) begin
                    $display("%0t: result with nothing expected: sample_out %0d block_end_out %b",
                             $time, sample, last);
                end
                return;
            end
            want = expected_slots.pop_front();
            if (sample !== want.sample || last !== want.block_end) begin
                mismatches++;
                if (mismatches <= REPORT_CAP) begin
                    $display("%0t: slot %0d expected sample_out %0d block_end_out %b, got %0d %b",
                             $time, slots_out, want.sample, want.block_end, sample, last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wosc_in_if  slot_in ();
    wosc_out_if slot_out ();

    // idle percentages of both sides, receiver hold-off in cycles
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    int hold_requests;
    int holds_served;
    int cycle_count;
    int setting_count;

    slot_scoreboard sb;

    wavetable_oscillator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_slot      (slot_in),
        .o_slot      (slot_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served     = hold_requests;
            recv_hold_cycles = HOLD_OFF_CYCLES;
        end
        if (recv_hold_cycles > 0) begin
            slot_out.ready <= 1'b0;
            recv_hold_cycles--;
        end else begin
            slot_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog plus both monitors, all sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            if (i_rst_n && slot_in.valid && slot_in.ready) begin
                sb.take_slot(slot_in.existing_sample, slot_in.block_end);
            end
            if (i_rst_n && slot_out.valid && slot_out.ready) begin
                sb.check_slot(slot_out.sample_out, slot_out.block_end_out);
            end
        end
    end

    // offer one slot after a random gap; returns at the falling edge after the transfer
    task automatic send_slot(input logic signed [15:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            slot_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        slot_in.valid           <= 1'b1;
        slot_in.existing_sample <= value;
        slot_in.block_end       <= last;
        @(posedge i_clk);
        while (!slot_in.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected slot has come out
    task automatic wait_drained();
        slot_in.valid <= 1'b0;
        while (sb.expected_slots.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // write all five registers, junk in unused data bits, then a write to an unused index
    task automatic apply_settings(input logic [1:0] wave, input logic [PHASE_W-1:0] inc,
                                  input logic [15:0] gain, input logic add,
                                  input logic [CHCNT_W-1:0] chans);
        logic [CFG_IDX_W-1:0]  index [6];
        logic [CFG_DATA_W-1:0] data [6];
        for (int k = 0; k < 6; k++) begin
            data[k] = CFG_DATA_W'($urandom);
        end
        index[0] = CFG_WAVEFORM;
        data[0][1:0] = wave;
        index[1] = CFG_PHASE_INC;
        data[1] = inc;
        index[2] = CFG_AMPLITUDE;
        data[2][15:0] = gain;
        index[3] = CFG_ADD_MODE;
        data[3][0] = add;
        index[4] = CFG_CHANNEL_COUNT;
        data[4][CHCNT_W-1:0] = chans;
        // indexes past the last register must leave everything alone
        index[5] = CFG_IDX_W'(CFG_CHANNEL_COUNT + 1 + $urandom_range(2));
        for (int k = 0; k < 6; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= index[k];
            cfg_data  <= data[k];
            sb.write_reg(index[k], data[k]);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // one random register setting followed by buffers of slots
    task automatic run_batch(input int batch);
        logic [1:0]         wave;
        logic [PHASE_W-1:0] inc;
        logic [15:0]        gain;
        logic [CHCNT_W-1:0] chans;
        logic signed [15:0] value;
        logic               last;
        int                 frame_len;
        int                 buf_len;
        int                 sent;
        wave = 2'($urandom);
        case ($urandom_range(3))
            0: inc = PHASE_W'($urandom_range(8 << PHASE_FRACTION_BITS));
            1: inc = -PHASE_W'($urandom_range(8 << PHASE_FRACTION_BITS));
            2: begin
                case ($urandom_range(3))
                    0: inc = {1'b0, {(PHASE_W - 1){1'b1}}};
                    1: inc = {1'b1, {(PHASE_W - 1){1'b0}}};
                    2: inc = '0;
                    default: inc = '1;
                endcase
            end
            default: inc = PHASE_W'($urandom);
        endcase
        case ($urandom_range(7))
            0: gain = '0;
            1: gain = 16'hFFFF;
            2: gain = 16'h8000;
            default: gain = 16'($urandom);
        endcase
        // mostly legal channel counts, sometimes zero or above eight
        chans = ($urandom_range(7) == 0) ? CHCNT_W'($urandom)
                                         : CHCNT_W'($urandom_range(1, MAX_CHANNELS));
        frame_len = (chans == 0) ? 1 : (chans > MAX_CHANNELS) ? MAX_CHANNELS : chans;
        wait_drained();
        apply_settings(wave, inc, gain, 1'($urandom), chans);
        sent = 0;
        while (sent < BATCH_SLOTS) begin
            // buffers are mostly whole frames, now and then cut short mid-frame
            buf_len = ($urandom_range(4) == 0) ? $urandom_range(1, 20)
                                               : frame_len * $urandom_range(1, 6);
            for (int k = 0; k < buf_len && sent < BATCH_SLOTS; k++) begin
                case ($urandom_range(7))
                    0: value = 16'sh7FFF;
                    1: value = 16'sh8000;
                    2: value = '0;
                    default: value = 16'($urandom);
                endcase
                last = (k == buf_len - 1) || ($urandom_range(39) == 0);
                // long receiver hold-off so the queue fills and the input stalls
                if (sent == 40 && batch % 4 == 0) begin
                    hold_requests++;
                end
                send_slot(value, last);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        slot_in.valid           = 1'b0;
        slot_in.existing_sample = '0;
        slot_in.block_end       = 1'b0;
        sb                      = new();
        send_idle_pct           = 35;
        recv_idle_pct           = 54;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: cosine at point zero, half gain, one channel
        repeat (3) send_slot(16'($urandom), 1'($urandom));

        // full gain cosine overflows in overwrite mode; a step of minus one lands
        // just below the table end, which rounds up and wraps to point zero
        wait_drained();
        apply_settings(WAVE_COSINE, '1, 16'hFFFF, 1'b1 ^ 1'b1, CHCNT_W'(1));
        repeat (4) send_slot(16'($urandom), 1'b0);

        // square at full gain alternating halves, add mode saturating both ways,
        // channel count zero behaves as one
        wait_drained();
        apply_settings(WAVE_SQUARE, PHASE_W'(HALF << PHASE_FRACTION_BITS), 16'hFFFF, 1'b1, '0);
        send_slot(16'sh7FFF, 1'b0);
        send_slot(16'sh8000, 1'b0);
        send_slot(16'sh8000, 1'b0);
        send_slot(16'sh7FFF, 1'b0);
        send_slot('0, 1'b0);

        // triangle, largest positive step, fifteen channels clamp to eight,
        // block end cuts the frame short
        wait_drained();
        apply_settings(WAVE_TRIANGLE, {1'b0, {(PHASE_W - 1){1'b1}}}, 16'h8000, 1'b1, '1);
        for (int k = 0; k < 6; k++) begin
            send_slot(16'($urandom), k == 2);
        end

        // sawtooth, most negative step, zero gain passes the existing value through
        wait_drained();
        apply_settings(WAVE_SAWTOOTH, {1'b1, {(PHASE_W - 1){1'b0}}}, '0, 1'b1,
                       CHCNT_W'(MAX_CHANNELS));
        repeat (4) send_slot(16'($urandom), 1'($urandom));

        // random part: receiver-heavy idling, then sender-heavy, then none
        for (int b = 0; b < BATCHES; b++) begin
            if (b == 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 35;
            end else if (b == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_batch(b);
        end

        // let any stray result show up before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d slots over %0d register settings: four waveforms, add and overwrite,",
                 sb.slots_in, setting_count);
        $display("odd channel counts, queue-full stalls; %0d results checked, %0d mismatches",
                 sb.slots_out, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_slots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
